@@ rtl/sdh_pkg.sv @@
// shared types, constants and helpers for the straight drive heading controller
package sdh_pkg;

  localparam logic [6:0] START_POWER = 7'd15;
  localparam logic [6:0] POWER_CEIL  = 7'd100;

  localparam logic [1:0] STATUS_IDLE     = 2'd0;
  localparam logic [1:0] STATUS_DRIVING  = 2'd1;
  localparam logic [1:0] STATUS_GOAL     = 2'd2;
  localparam logic [1:0] STATUS_OBSTACLE = 2'd3;

  localparam logic KIND_START  = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  localparam logic [2:0] REG_GAIN_PROP     = 3'd0;
  localparam logic [2:0] REG_GAIN_INT      = 3'd1;
  localparam logic [2:0] REG_GAIN_DERIV    = 3'd2;
  localparam logic [2:0] REG_POWER_MAX     = 3'd3;
  localparam logic [2:0] REG_RAMP_LIMIT    = 3'd4;
  localparam logic [2:0] REG_RAMP_STEP     = 3'd5;
  localparam logic [2:0] REG_COUNTS_PER_CM = 3'd6;

  localparam int ADDR_W = 5;
  localparam int SUM_W  = 51;
  localparam int MAG_W  = SUM_W - 16;

  typedef struct packed {
    logic               kind;
    logic [11:0]        target_distance;
    logic signed [15:0] heading_error;
    logic signed [7:0]  motion_dy;
    logic               ramp_due;
    logic               obstacle_front;
  } sdh_cmd_t;

  typedef struct packed {
    logic [6:0]         left_power;
    logic [6:0]         power_right;
    logic [1:0]         run_status;
    logic signed [31:0] travelled_counts;
  } sdh_res_t;

  typedef struct packed {
    logic               pid;
    logic [6:0]         base;
    logic [1:0]         status;
    logic signed [31:0] travel;
  } sdh_ctl_t;

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    if (v > 34'sh0_7FFF_FFFF) begin
      return 32'sh7FFF_FFFF;
    end else if (v < 34'sh3_8000_0000) begin
      return 32'sh8000_0000;
    end else begin
      return v[31:0];
    end
  endfunction

endpackage

@@ rtl/straight_drive_heading_pid.sv @@
// straight drive controller: heading pid with ramped base power and distance goal
// throughput: one command per cycle unless res_stall holds the output; run state updates from the input register,
// the pid multiplies, sum, magnitude and clamp follow in four pipeline stages
// reset: synchronous; registers return to defaults, run state clears, no clearing pass
module straight_drive_heading_pid (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cmd_valid,
  output logic                         cmd_stall,
  input  sdh_pkg::sdh_cmd_t            cmd,
  output logic                         res_valid,
  input  logic                         res_stall,
  output sdh_pkg::sdh_res_t            res,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [sdh_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import sdh_pkg::*;

  // config registers
  logic [15:0] gain_prop, gain_int, gain_deriv, counts_per_cm;
  logic [6:0]  power_max, ramp_limit, ramp_step;
  logic [2:0]  reg_idx;

  // run state
  logic [6:0]         base_power, base_power_next;
  logic signed [31:0] integral_sum, integral_sum_next;
  logic signed [15:0] previous_error, previous_error_next;
  logic signed [31:0] travel_sum, travel_sum_next;
  logic signed [31:0] goal_counts, goal_counts_next;
  logic               driving, driving_next;

  // pipeline
  logic                      s0_valid, s1_valid, s2_valid, s3_valid, s4_valid;
  logic                      rdy0, rdy1, rdy2, rdy3, rdy4, out_free;
  sdh_cmd_t                  cmd_q;
  logic signed [15:0]        s1_e;
  logic signed [16:0]        s1_d;
  logic signed [31:0]        s1_integ;
  sdh_ctl_t                  s1_ctl, a_ctl;
  logic signed [32:0]        s2_pp;
  logic signed [48:0]        s2_ip;
  logic signed [33:0]        s2_dp;
  sdh_ctl_t                  s2_ctl;
  logic signed [SUM_W-1:0]   s3_sum;
  sdh_ctl_t                  s3_ctl;
  logic                      s4_neg;
  logic [MAG_W-1:0]          s4_mag;
  sdh_ctl_t                  s4_ctl;

  // stage a helpers
  logic [27:0]        ahead_prod;
  logic signed [33:0] goal_wide, travel_wide, integ_wide;
  logic [7:0]         ramp_sum;
  logic signed [16:0] d_val;

  // stage helpers
  logic signed [SUM_W-1:0] abs_sum;
  logic [6:0]              top, up_c, dn_c, dn_diff;
  logic [MAG_W:0]          up_wide;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_prop     <= 16'd768;
      gain_int      <= 16'd6;
      gain_deriv    <= 16'd768;
      power_max     <= 7'd45;
      ramp_limit    <= 7'd40;
      ramp_step     <= 7'd5;
      counts_per_cm <= 16'd11315;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_GAIN_PROP:     gain_prop     <= pwdata[15:0];
        REG_GAIN_INT:      gain_int      <= pwdata[15:0];
        REG_GAIN_DERIV:    gain_deriv    <= pwdata[15:0];
        REG_POWER_MAX:     power_max     <= pwdata[6:0];
        REG_RAMP_LIMIT:    ramp_limit    <= pwdata[6:0];
        REG_RAMP_STEP:     ramp_step     <= pwdata[6:0];
        REG_COUNTS_PER_CM: counts_per_cm <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_GAIN_PROP:     prdata = {16'd0, gain_prop};
      REG_GAIN_INT:      prdata = {16'd0, gain_int};
      REG_GAIN_DERIV:    prdata = {16'd0, gain_deriv};
      REG_POWER_MAX:     prdata = {25'd0, power_max};
      REG_RAMP_LIMIT:    prdata = {25'd0, ramp_limit};
      REG_RAMP_STEP:     prdata = {25'd0, ramp_step};
      REG_COUNTS_PER_CM: prdata = {16'd0, counts_per_cm};
      default:           prdata = 32'd0;
    endcase
  end

  // flow control
  assign out_free  = !res_valid || !res_stall;
  assign rdy4      = !s4_valid || out_free;
  assign rdy3      = !s3_valid || rdy4;
  assign rdy2      = !s2_valid || rdy3;
  assign rdy1      = !s1_valid || rdy2;
  assign rdy0      = !s0_valid || rdy1;
  assign cmd_stall = !rdy0;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid  <= 1'b0;
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (rdy0)     s0_valid  <= cmd_valid;
      if (rdy1)     s1_valid  <= s0_valid;
      if (rdy2)     s2_valid  <= s1_valid;
      if (rdy3)     s3_valid  <= s2_valid;
      if (rdy4)     s4_valid  <= s3_valid;
      if (out_free) res_valid <= s4_valid;
    end
  end

  // run state update
  assign ahead_prod  = cmd_q.target_distance * counts_per_cm;
  assign goal_wide   = 34'(travel_sum) + $signed({14'd0, ahead_prod[27:8]});
  assign travel_wide = 34'(travel_sum) + 34'($signed(cmd_q.motion_dy));
  assign integ_wide  = 34'(integral_sum) + 34'($signed(cmd_q.heading_error));
  assign ramp_sum    = {1'b0, base_power} + {1'b0, ramp_step};
  assign d_val       = 17'($signed(cmd_q.heading_error)) - 17'(previous_error);

  always_comb begin
    base_power_next     = base_power;
    integral_sum_next   = integral_sum;
    previous_error_next = previous_error;
    travel_sum_next     = travel_sum;
    goal_counts_next    = goal_counts;
    driving_next        = driving;
    a_ctl.pid           = 1'b0;
    a_ctl.status        = STATUS_IDLE;
    if (cmd_q.kind == KIND_START) begin
      goal_counts_next = sat32(goal_wide);
      driving_next     = 1'b1;
      a_ctl.status     = STATUS_DRIVING;
    end else if (driving) begin
      if (travel_sum >= goal_counts) begin
        driving_next = 1'b0;
        a_ctl.status = STATUS_GOAL;
      end else if (cmd_q.obstacle_front) begin
        driving_next = 1'b0;
        a_ctl.status = STATUS_OBSTACLE;
      end else begin
        if (cmd_q.ramp_due && (base_power < ramp_limit)) begin
          base_power_next = (ramp_sum > 8'(POWER_CEIL)) ? POWER_CEIL : ramp_sum[6:0];
        end
        travel_sum_next = sat32(travel_wide);
        if (cmd_q.heading_error == 16'sd0) begin
          integral_sum_next = 32'sd0;
        end else begin
          integral_sum_next = sat32(integ_wide);
        end
        previous_error_next = cmd_q.heading_error;
        a_ctl.pid           = 1'b1;
        a_ctl.status        = STATUS_DRIVING;
      end
    end
    a_ctl.base   = base_power_next;
    a_ctl.travel = travel_sum_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_power     <= START_POWER;
      integral_sum   <= 32'sd0;
      previous_error <= 16'sd0;
      travel_sum     <= 32'sd0;
      goal_counts    <= 32'sd0;
      driving        <= 1'b0;
    end else if (s0_valid && rdy1) begin
      base_power     <= base_power_next;
      integral_sum   <= integral_sum_next;
      previous_error <= previous_error_next;
      travel_sum     <= travel_sum_next;
      goal_counts    <= goal_counts_next;
      driving        <= driving_next;
    end
  end

  // magnitude and clamp
  assign abs_sum = s3_sum[SUM_W-1] ? -s3_sum : s3_sum;
  assign top     = (power_max > POWER_CEIL) ? POWER_CEIL : power_max;
  assign up_wide = {{(MAG_W+1-7){1'b0}}, s4_ctl.base} + {1'b0, s4_mag};
  assign up_c    = (up_wide > (MAG_W+1)'(top)) ? top : up_wide[6:0];
  assign dn_diff = s4_ctl.base - s4_mag[6:0];

  always_comb begin
    if (s4_mag > MAG_W'(s4_ctl.base)) begin
      dn_c = 7'd0;
    end else if (dn_diff > top) begin
      dn_c = top;
    end else begin
      dn_c = dn_diff;
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    if (rdy0) cmd_q <= cmd;
    if (rdy1) begin
      s1_e     <= cmd_q.heading_error;
      s1_d     <= d_val;
      s1_integ <= integral_sum_next;
      s1_ctl   <= a_ctl;
    end
    if (rdy2) begin
      s2_pp  <= $signed({1'b0, gain_prop}) * s1_e;
      s2_ip  <= $signed({1'b0, gain_int}) * s1_integ;
      s2_dp  <= $signed({1'b0, gain_deriv}) * s1_d;
      s2_ctl <= s1_ctl;
    end
    if (rdy3) begin
      s3_sum <= SUM_W'(s2_pp) + SUM_W'(s2_ip) + SUM_W'(s2_dp);
      s3_ctl <= s2_ctl;
    end
    if (rdy4) begin
      s4_neg <= s3_sum[SUM_W-1];
      s4_mag <= abs_sum[SUM_W-1:16];
      s4_ctl <= s3_ctl;
    end
    if (out_free) begin
      res.run_status       <= s4_ctl.status;
      res.travelled_counts <= s4_ctl.travel;
      if (s4_ctl.pid) begin
        res.left_power  <= s4_neg ? dn_c : up_c;
        res.power_right <= s4_neg ? up_c : dn_c;
      end else begin
        res.left_power  <= 7'd0;
        res.power_right <= 7'd0;
      end
    end
  end

endmodule
